### hw/rtl/swsc_pkg.sv
// Shared constants, codes and the arctangent step table for the
// six-wheel steer and speed controller. No dependencies.
package swsc_pkg;

    // angle word, Q.16 radians
    localparam int W_ANG = 20;
    // rotation CORDIC datapath, Q2.30
    localparam int W_ROT = 33;
    // Ackermann terms A, B, Y, D and magnitudes, Q.30
    localparam int W_AB  = 34;
    // vectoring CORDIC datapath
    localparam int W_VX  = 36;
    // divider numerator / denominator
    localparam int W_NUM = 52;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_PER_STG = 4;
    localparam int CORDIC_STGS  = CORDIC_STEPS / STEP_PER_STG;
    localparam int ROT_LAT      = CORDIC_STGS;
    localparam int VEC_LAT      = CORDIC_STGS + 2;
    localparam int DIV_BITS     = 32;
    localparam int DIV_STGS     = DIV_BITS / STEP_PER_STG;
    localparam int DIV_LAT      = DIV_STGS + 2;

    localparam logic signed [W_ANG-1:0] ANG_PI    = 20'sd205887;
    localparam logic signed [W_ANG-1:0] ANG_PI_2  = 20'sd102944;
    localparam logic signed [W_ANG-1:0] ANG_PI_4  = 20'sd51472;
    localparam logic signed [W_ANG-1:0] ANG_3PI_4 = 20'sd154416;
    localparam logic [30:0]             CORDIC_K  = 31'd652032874;
    localparam logic signed [W_AB-1:0]  UNIT_Q30  = 34'sd1073741824;

    typedef enum logic [2:0] {
        REG_GAIN_PROP   = 3'd0,
        REG_GAIN_DERIV  = 3'd1,
        REG_TRACK_WIDTH = 3'd2,
        REG_BASE_LENGTH = 3'd3,
        REG_WHEEL_RAD   = 3'd4,
        REG_SPEED_LIMIT = 3'd5
    } t_reg_idx;

    localparam logic [1:0] MODE_CONT  = 2'd0;
    localparam logic [1:0] MODE_POINT = 2'd1;
    localparam logic [1:0] MODE_HOLD  = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [2:0] WHEEL_MR = 3'd2;
    localparam logic [2:0] WHEEL_ML = 3'd3;

    // atan(2^-i) in Q.16 radians
    function automatic logic signed [W_ANG-1:0] arc_step(input int i);
        logic signed [W_ANG-1:0] a;
        case (i)
            0:  a = 20'sd51472;
            1:  a = 20'sd30386;
            2:  a = 20'sd16055;
            3:  a = 20'sd8150;
            4:  a = 20'sd4091;
            5:  a = 20'sd2047;
            6:  a = 20'sd1024;
            7:  a = 20'sd512;
            8:  a = 20'sd256;
            9:  a = 20'sd128;
            10: a = 20'sd64;
            11: a = 20'sd32;
            12: a = 20'sd16;
            13: a = 20'sd8;
            14: a = 20'sd4;
            15: a = 20'sd2;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### hw/rtl/swsc_rot.sv
// Pipelined rotation CORDIC: sine and cosine of a Q.16 angle in Q2.30.
// Depends on swsc_pkg.
module swsc_rot (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [swsc_pkg::W_ANG-1:0]   i_theta,
    output logic signed [swsc_pkg::W_ROT-1:0]   o_sin,
    output logic signed [swsc_pkg::W_ROT-1:0]   o_cos
);

    typedef struct packed {
        logic signed [swsc_pkg::W_ROT-1:0] x;
        logic signed [swsc_pkg::W_ROT-1:0] y;
        logic signed [swsc_pkg::W_ANG-1:0] z;
    } t_rot;

    function automatic t_rot f_step4(input t_rot st, input int first);
        t_rot s;
        logic signed [swsc_pkg::W_ROT-1:0] dx;
        logic signed [swsc_pkg::W_ROT-1:0] dy;
        s = st;
        for (int k = 0; k < swsc_pkg::STEP_PER_STG; k++) begin
            dx = s.y >>> (first + k);
            dy = s.x >>> (first + k);
            if (s.z >= 0) begin
                s.x = s.x - dx;
                s.y = s.y + dy;
                s.z = s.z - swsc_pkg::arc_step(first + k);
            end else begin
                s.x = s.x + dx;
                s.y = s.y - dy;
                s.z = s.z + swsc_pkg::arc_step(first + k);
            end
        end
        return s;
    endfunction

    t_rot w_seed;
    t_rot n_st [swsc_pkg::CORDIC_STGS];
    t_rot r_st [swsc_pkg::CORDIC_STGS];

    assign w_seed.x = swsc_pkg::W_ROT'(swsc_pkg::CORDIC_K);
    assign w_seed.y = '0;
    assign w_seed.z = i_theta;

    for (genvar j = 0; j < swsc_pkg::CORDIC_STGS; j++) begin : g_stg
        if (j == 0) begin : g_first
            assign n_st[j] = f_step4(w_seed, 0);
        end else begin : g_next
            assign n_st[j] = f_step4(r_st[j-1], j * swsc_pkg::STEP_PER_STG);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign o_sin = r_st[swsc_pkg::CORDIC_STGS-1].y;
    assign o_cos = r_st[swsc_pkg::CORDIC_STGS-1].x;

endmodule

### hw/rtl/swsc_vec.sv
// Pipelined vectoring CORDIC: atan2(y, x) in Q.16 and the vector length.
// Depends on swsc_pkg.
module swsc_vec (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [swsc_pkg::W_AB-1:0]    i_x,
    input  logic signed [swsc_pkg::W_AB-1:0]    i_y,
    output logic signed [swsc_pkg::W_ANG-1:0]   o_ang,
    output logic signed [swsc_pkg::W_AB-1:0]    o_mag
);

    typedef struct packed {
        logic signed [swsc_pkg::W_VX-1:0]  x;
        logic signed [swsc_pkg::W_VX-1:0]  y;
        logic signed [swsc_pkg::W_ANG-1:0] z;
        logic                              yz;
        logic                              xneg;
        logic signed [swsc_pkg::W_AB-1:0]  absx;
    } t_vec;

    localparam logic signed [swsc_pkg::W_VX+31:0] K_EXT =
        (swsc_pkg::W_VX+32)'(swsc_pkg::CORDIC_K);

    function automatic t_vec f_step4(input t_vec st, input int first);
        t_vec s;
        logic signed [swsc_pkg::W_VX-1:0] dx;
        logic signed [swsc_pkg::W_VX-1:0] dy;
        s = st;
        for (int k = 0; k < swsc_pkg::STEP_PER_STG; k++) begin
            dx = s.y >>> (first + k);
            dy = s.x >>> (first + k);
            if (s.y > 0) begin
                s.x = s.x + dx;
                s.y = s.y - dy;
                s.z = s.z + swsc_pkg::arc_step(first + k);
            end else begin
                s.x = s.x - dx;
                s.y = s.y + dy;
                s.z = s.z - swsc_pkg::arc_step(first + k);
            end
        end
        return s;
    endfunction

    t_vec n_pre;
    t_vec r_pre;
    t_vec n_st [swsc_pkg::CORDIC_STGS];
    t_vec r_st [swsc_pkg::CORDIC_STGS];
    logic signed [swsc_pkg::W_VX+31:0] w_prod;
    logic signed [swsc_pkg::W_ANG-1:0] r_ang;
    logic signed [swsc_pkg::W_AB-1:0]  r_mag;

    // fold the left half plane onto the right one
    always_comb begin
        n_pre.x    = swsc_pkg::W_VX'(i_x);
        n_pre.y    = swsc_pkg::W_VX'(i_y);
        n_pre.z    = '0;
        n_pre.yz   = (i_y == '0);
        n_pre.xneg = (i_x < 0);
        n_pre.absx = (i_x < 0) ? -i_x : i_x;
        if (i_y != '0 && i_x < 0) begin
            n_pre.z = (i_y >= 0) ? swsc_pkg::ANG_PI : -swsc_pkg::ANG_PI;
            n_pre.x = -n_pre.x;
            n_pre.y = -n_pre.y;
        end
    end

    for (genvar j = 0; j < swsc_pkg::CORDIC_STGS; j++) begin : g_stg
        if (j == 0) begin : g_first
            assign n_st[j] = f_step4(r_pre, 0);
        end else begin : g_next
            assign n_st[j] = f_step4(r_st[j-1], j * swsc_pkg::STEP_PER_STG);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign w_prod = (swsc_pkg::W_VX+32)'(r_st[swsc_pkg::CORDIC_STGS-1].x) * K_EXT;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
            if (r_st[swsc_pkg::CORDIC_STGS-1].yz) begin
                r_ang <= r_st[swsc_pkg::CORDIC_STGS-1].xneg ? swsc_pkg::ANG_PI : '0;
                r_mag <= r_st[swsc_pkg::CORDIC_STGS-1].absx;
            end else begin
                r_ang <= r_st[swsc_pkg::CORDIC_STGS-1].z;
                r_mag <= w_prod[swsc_pkg::W_AB+29:30];
            end
        end
    end

    assign o_ang = r_ang;
    assign o_mag = r_mag;

endmodule

### hw/rtl/swsc_div.sv
// Pipelined signed divider: saturating floor(|num| * 2^18 / |den|) with sign,
// four quotient bits per stage. Depends on swsc_pkg.
module swsc_div (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [swsc_pkg::W_NUM-1:0]   i_num,
    input  logic signed [swsc_pkg::W_NUM-1:0]   i_den,
    output logic signed [31:0]                  o_quo
);

    typedef struct packed {
        logic [swsc_pkg::W_NUM-1:0] rem;
        logic [31:0]                ext;
        logic [31:0]                q;
        logic [swsc_pkg::W_NUM-1:0] ud;
        logic                       neg;
        logic                       dz;
        logic                       nz;
        logic                       ovf;
        logic                       nsg;
    } t_div;

    function automatic t_div f_step4(input t_div st);
        t_div s;
        logic [swsc_pkg::W_NUM:0] r;
        s = st;
        for (int k = 0; k < swsc_pkg::STEP_PER_STG; k++) begin
            r     = {s.rem, s.ext[31]};
            s.ext = {s.ext[30:0], 1'b0};
            if (r >= {1'b0, s.ud}) begin
                r   = r - {1'b0, s.ud};
                s.q = {s.q[30:0], 1'b1};
            end else begin
                s.q = {s.q[30:0], 1'b0};
            end
            s.rem = r[swsc_pkg::W_NUM-1:0];
        end
        return s;
    endfunction

    t_div n_pre;
    t_div r_pre;
    t_div n_st [swsc_pkg::DIV_STGS];
    t_div r_st [swsc_pkg::DIV_STGS];
    t_div w_last;
    logic [swsc_pkg::W_NUM-1:0] w_un;
    logic [swsc_pkg::W_NUM-1:0] w_ud;
    logic [32:0] w_lim;
    logic signed [31:0] n_quo;
    logic signed [31:0] r_quo;

    assign w_un = (i_num < 0) ? swsc_pkg::W_NUM'(-i_num) : swsc_pkg::W_NUM'(i_num);
    assign w_ud = (i_den < 0) ? swsc_pkg::W_NUM'(-i_den) : swsc_pkg::W_NUM'(i_den);

    always_comb begin
        n_pre.rem = w_un >> 14;
        n_pre.ext = {w_un[13:0], 18'd0};
        n_pre.q   = '0;
        n_pre.ud  = w_ud;
        n_pre.neg = (i_num < 0) != (i_den < 0);
        n_pre.dz  = (w_ud == '0);
        n_pre.nz  = (w_un == '0);
        // quotient of 2^32 or more
        n_pre.ovf = {14'd0, w_un} >= {w_ud, 14'd0};
        n_pre.nsg = (i_num < 0);
    end

    for (genvar j = 0; j < swsc_pkg::DIV_STGS; j++) begin : g_stg
        if (j == 0) begin : g_first
            assign n_st[j] = f_step4(r_pre);
        end else begin : g_next
            assign n_st[j] = f_step4(r_st[j-1]);
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[j] <= n_st[j];
            end
        end
    end

    assign w_last = r_st[swsc_pkg::DIV_STGS-1];
    assign w_lim  = w_last.neg ? 33'h080000000 : 33'h07FFFFFFF;

    always_comb begin
        if (w_last.dz) begin
            if (w_last.nz) begin
                n_quo = '0;
            end else begin
                n_quo = w_last.nsg ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
        end else if (w_last.ovf || {1'b0, w_last.q} > w_lim) begin
            n_quo = w_last.neg ? 32'sh80000000 : 32'sh7FFFFFFF;
        end else begin
            n_quo = w_last.neg ? -$signed(w_last.q) : $signed(w_last.q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre <= n_pre;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

### hw/rtl/six_wheel_steer_speed_controller_core.sv
// Six-wheel steer and speed controller core: Ackermann geometry with a PD
// steering term per wheel. Depends on swsc_pkg, swsc_rot, swsc_vec, swsc_div.
//
// Usage:
//  - Input channel (i_in_valid / o_in_ready) carries one wheel request: wheel
//    index, speed, steer and mode commands, measured joint angle and rate.
//  - Output channel (o_out_valid / i_out_ready) returns one result for every
//    request, in order: wheel echo, steer rate and spin rate, Q16.16.
//  - One request enters per cycle while the output is not stalled. The pipeline
//    depth is set by the CORDIC chains (four steps a stage) and the 32-bit
//    quotient divider (four bits a stage).
//  - Whenever the output register holds a result that is not taken, the whole
//    pipeline holds and o_in_ready drops; nothing is lost or repeated.
//  - The APB port writes the six gain and geometry registers at byte address
//    4*index; write them only with the pipeline empty.
//  - Reset (synchronous, active low) empties the pipeline, loads the register
//    defaults and clears the held per-wheel rates to zero.
//  - Hold mode (and the unused mode) returns the last rates stored for the
//    wheel; wheel indices six and seven return zeros and store nothing.
module six_wheel_steer_speed_controller_core #(
    parameter int NUM_WHEELS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [2:0]         i_wheel_sel,
    input  logic signed [15:0] i_speed_cmd,
    input  logic signed [15:0] i_steer_cmd,
    input  logic [1:0]         i_drive_mode,
    input  logic signed [15:0] i_joint_angle,
    input  logic signed [15:0] i_joint_rate,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_wheel_echo,
    output logic signed [31:0] o_steer_rate_out,
    output logic signed [31:0] o_spin_rate_out,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int W_ANG = swsc_pkg::W_ANG;
    localparam int W_AB  = swsc_pkg::W_AB;
    localparam int W_NUM = swsc_pkg::W_NUM;
    localparam int W_P   = 51;
    localparam int W_E   = 22;
    localparam int W_PE  = 40;
    localparam int W_ACC = 41;

    // stage positions of the sideband pipeline
    localparam int S_ROT_OUT = swsc_pkg::ROT_LAT;
    localparam int S_PROD    = S_ROT_OUT + 1;
    localparam int S_AB      = S_PROD + 1;
    localparam int S_VEC_OUT = S_AB + swsc_pkg::VEC_LAT;
    localparam int S_TGT     = S_VEC_OUT + 1;
    localparam int S_SEL     = S_TGT + 1;
    localparam int S_STEER   = S_SEL + 1;
    localparam int S_DIV_OUT = S_STEER + swsc_pkg::DIV_LAT;
    localparam int SB_DEPTH  = S_DIV_OUT + 1;
    localparam int LAST      = SB_DEPTH;
    localparam int W_WIDX    = $clog2(NUM_WHEELS);

    typedef struct packed {
        logic [2:0]               sel;
        logic [1:0]               mode;
        logic signed [15:0]       v;
        logic signed [W_ANG-1:0]  thr;
        logic                     th_hi;
        logic                     th_lo;
        logic signed [15:0]       ang;
        logic signed [15:0]       rate;
        logic signed [W_AB-1:0]   a;
        logic signed [W_AB-1:0]   bb;
        logic signed [W_AB-1:0]   y;
        logic signed [W_AB-1:0]   d;
        logic signed [W_AB-1:0]   hl;
        logic signed [W_AB-1:0]   hr;
        logic signed [W_E-1:0]    e;
        logic signed [16:0]       sq;
        logic signed [W_AB-1:0]   n;
        logic signed [W_AB-1:0]   sd;
        logic signed [31:0]       steer;
    } t_side;

    // ---------------- configuration registers ----------------
    logic [15:0] r_gain_prop;
    logic [15:0] r_gain_deriv;
    logic [15:0] r_track_width;
    logic [15:0] r_base_length;
    logic [15:0] r_wheel_rad;
    logic [14:0] r_speed_limit;
    logic        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_prop   <= 16'd2048;
            r_gain_deriv  <= 16'd0;
            r_track_width <= 16'd19661;
            r_base_length <= 16'd19988;
            r_wheel_rad   <= 16'd2294;
            r_speed_limit <= 15'd1638;
        end else if (w_cfg_wr) begin
            unique case (paddr[4:2])
                swsc_pkg::REG_GAIN_PROP:   r_gain_prop   <= pwdata[15:0];
                swsc_pkg::REG_GAIN_DERIV:  r_gain_deriv  <= pwdata[15:0];
                swsc_pkg::REG_TRACK_WIDTH: r_track_width <= pwdata[15:0];
                swsc_pkg::REG_BASE_LENGTH: r_base_length <= pwdata[15:0];
                swsc_pkg::REG_WHEEL_RAD:   r_wheel_rad   <= pwdata[15:0];
                swsc_pkg::REG_SPEED_LIMIT: r_speed_limit <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            swsc_pkg::REG_GAIN_PROP:   prdata = {16'd0, r_gain_prop};
            swsc_pkg::REG_GAIN_DERIV:  prdata = {16'd0, r_gain_deriv};
            swsc_pkg::REG_TRACK_WIDTH: prdata = {16'd0, r_track_width};
            swsc_pkg::REG_BASE_LENGTH: prdata = {16'd0, r_base_length};
            swsc_pkg::REG_WHEEL_RAD:   prdata = {16'd0, r_wheel_rad};
            swsc_pkg::REG_SPEED_LIMIT: prdata = {17'd0, r_speed_limit};
            default:                   prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // The whole pipeline advances together; it holds only when the output
    // register is full and the receiver does not take the result.
    logic            w_en;
    logic [LAST:0]   r_vld;
    t_side           r_sb [SB_DEPTH];
    t_side           n_sb [SB_DEPTH];

    assign w_en       = !r_vld[LAST] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_in_valid};
        end
    end

    // ---------------- stage 0: clamp speed, reduce steer angle ----------------
    logic signed [16:0]      w_v17;
    logic signed [16:0]      w_m17;
    logic signed [16:0]      w_vcl;
    logic signed [W_ANG-1:0] w_th;
    logic signed [W_ANG-1:0] w_thr;

    assign w_v17 = 17'(i_speed_cmd);
    assign w_m17 = {2'b00, r_speed_limit};
    assign w_th  = W_ANG'($signed({i_steer_cmd, 3'b000}));

    always_comb begin
        w_vcl = w_v17;
        if (w_vcl > w_m17) begin
            w_vcl = w_m17;
        end
        if (w_vcl < -w_m17) begin
            w_vcl = -w_m17;
        end
        w_thr = w_th;
        if (w_thr > swsc_pkg::ANG_PI_2) begin
            w_thr = w_thr - swsc_pkg::ANG_PI;
        end
        if (w_thr < -swsc_pkg::ANG_PI_2) begin
            w_thr = w_thr + swsc_pkg::ANG_PI;
        end
    end

    // ---------------- sin / cos of the reduced angle ----------------
    logic signed [swsc_pkg::W_ROT-1:0] w_sin;
    logic signed [swsc_pkg::W_ROT-1:0] w_cos;

    swsc_rot u_rot (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_theta (r_sb[0].thr),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // ---------------- products l*c, b*s, l*s ----------------
    logic signed [swsc_pkg::W_ROT-1:0] w_ccl;
    logic signed [W_P-1:0] r_lc;
    logic signed [W_P-1:0] r_bs;
    logic signed [W_P-1:0] r_ls;
    logic signed [W_P-1:0] w_amb;
    logic signed [W_P-1:0] w_apb;
    logic signed [W_AB-1:0] w_d;

    // keep the cosine at least one LSB
    assign w_ccl = (w_cos < 1) ? swsc_pkg::W_ROT'(1) : w_cos;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lc <= W_P'($signed({1'b0, r_base_length})) * W_P'(w_ccl);
            r_bs <= W_P'($signed({1'b0, r_track_width})) * W_P'(w_sin);
            r_ls <= W_P'($signed({1'b0, r_base_length})) * W_P'(w_sin);
        end
    end

    assign w_amb = r_lc - r_bs;
    assign w_apb = r_lc + r_bs;
    assign w_d   = (r_lc[W_AB+15:16] < 1) ? W_AB'(1) : r_lc[W_AB+15:16];

    // ---------------- left and right Ackermann angles ----------------
    logic signed [W_ANG-1:0] w_al;
    logic signed [W_ANG-1:0] w_ar;
    logic signed [W_AB-1:0]  w_hl;
    logic signed [W_AB-1:0]  w_hr;

    swsc_vec u_vec_l (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_sb[S_AB].a),
        .i_y   (r_sb[S_AB].y),
        .o_ang (w_al),
        .o_mag (w_hl)
    );

    swsc_vec u_vec_r (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_sb[S_AB].bb),
        .i_y   (r_sb[S_AB].y),
        .o_ang (w_ar),
        .o_mag (w_hr)
    );

    // ---------------- steering target and limit products ----------------
    t_side                   w_vo;
    logic                    w_left;
    logic                    w_mid;
    logic                    w_front;
    logic signed [W_ANG-1:0] w_tl;
    logic signed [W_ANG-1:0] w_tr;
    logic signed [W_ANG-1:0] w_tgt;
    logic signed [W_P-1:0]   r_va;
    logic signed [W_P-1:0]   r_vb;
    logic signed [W_P-1:0]   r_md;

    assign w_vo    = r_sb[S_VEC_OUT];
    assign w_left  = w_vo.sel[0];
    assign w_mid   = (w_vo.sel == swsc_pkg::WHEEL_MR) || (w_vo.sel == swsc_pkg::WHEEL_ML);
    assign w_front = (w_vo.sel < swsc_pkg::WHEEL_MR);

    always_comb begin
        // at or beyond the quarter turn the targets are fixed
        if (w_vo.th_hi) begin
            w_tl = swsc_pkg::ANG_3PI_4;
            w_tr = swsc_pkg::ANG_PI_4;
        end else if (w_vo.th_lo) begin
            w_tl = -swsc_pkg::ANG_PI_4;
            w_tr = -swsc_pkg::ANG_3PI_4;
        end else begin
            w_tl = w_al;
            w_tr = w_ar;
        end
        if (w_mid) begin
            w_tgt = '0;
        end else if (w_vo.mode == swsc_pkg::MODE_CONT) begin
            if (w_front) begin
                w_tgt = w_left ? w_tl : w_tr;
            end else begin
                w_tgt = w_left ? -w_tl : -w_tr;
            end
        end else if (w_front) begin
            w_tgt = w_left ? -swsc_pkg::ANG_PI_4 : swsc_pkg::ANG_PI_4;
        end else begin
            w_tgt = w_left ? swsc_pkg::ANG_PI_4 : -swsc_pkg::ANG_PI_4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_va <= W_P'(w_vo.v) * W_P'(w_vo.a);
            r_vb <= W_P'(w_vo.v) * W_P'(w_vo.bb);
            r_md <= W_P'($signed({1'b0, r_speed_limit})) * W_P'(w_vo.d);
        end
    end

    // ---------------- PD products, spin operand selection ----------------
    t_side                 w_so;
    logic                  w_s_left;
    logic                  w_s_mid;
    logic signed [W_PE-1:0] r_pe;
    logic signed [W_PE-1:0] r_pd;
    logic signed [16:0]    w_sq;
    logic signed [W_AB-1:0] w_n;
    logic signed [W_AB-1:0] w_sd;
    logic signed [16:0]    w_ms;

    assign w_so     = r_sb[S_TGT];
    assign w_s_left = w_so.sel[0];
    assign w_s_mid  = (w_so.sel == swsc_pkg::WHEEL_MR) || (w_so.sel == swsc_pkg::WHEEL_ML);
    assign w_ms     = {2'b00, r_speed_limit};

    always_comb begin
        if (w_so.mode == swsc_pkg::MODE_CONT) begin
            // limit the faster side, keep the ratio between the sides
            if (r_va > r_md) begin
                w_sq = w_ms;
                w_sd = w_so.a;
            end else if (r_va < -r_md) begin
                w_sq = -w_ms;
                w_sd = w_so.a;
            end else if (r_vb > r_md) begin
                w_sq = w_ms;
                w_sd = w_so.bb;
            end else if (r_vb < -r_md) begin
                w_sq = -w_ms;
                w_sd = w_so.bb;
            end else begin
                w_sq = 17'(w_so.v);
                w_sd = w_so.d;
            end
            w_n = w_s_left ? (w_s_mid ? w_so.a : w_so.hl) : (w_s_mid ? w_so.bb : w_so.hr);
        end else begin
            w_sq = w_s_left ? -17'(w_so.v) : 17'(w_so.v);
            if (w_s_mid) begin
                w_n  = swsc_pkg::UNIT_Q30;
                w_sd = swsc_pkg::UNIT_Q30;
            end else begin
                w_n  = w_s_left ? w_so.hl : w_so.hr;
                w_sd = w_s_left ? w_so.a : w_so.bb;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pe <= W_PE'(w_so.e) * W_PE'($signed({1'b0, r_gain_prop}));
            r_pd <= W_PE'(w_so.rate) * W_PE'($signed({1'b0, r_gain_deriv}));
        end
    end

    // ---------------- steer accumulate, spin numerator / denominator ----------
    t_side                   w_po;
    logic signed [W_ACC-1:0] w_acc;
    logic signed [W_ACC-9:0] w_accs;
    logic signed [31:0]      w_steer;
    logic signed [W_NUM-1:0] r_num;
    logic signed [W_NUM-1:0] r_den;
    logic signed [31:0]      w_spin;

    assign w_po   = r_sb[S_SEL];
    assign w_acc  = W_ACC'(r_pe) - (W_ACC'(r_pd) <<< 4);
    assign w_accs = w_acc[W_ACC-1:8];

    always_comb begin
        if (w_accs > (W_ACC-8)'(32'sh7FFFFFFF)) begin
            w_steer = 32'sh7FFFFFFF;
        end else if (w_accs < (W_ACC-8)'(32'sh80000000)) begin
            w_steer = 32'sh80000000;
        end else begin
            w_steer = w_accs[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_num <= W_NUM'(w_po.sq) * W_NUM'(w_po.n);
            r_den <= W_NUM'(w_po.sd) * W_NUM'($signed({1'b0, r_wheel_rad}));
        end
    end

    swsc_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num),
        .i_den (r_den),
        .o_quo (w_spin)
    );

    // ---------------- sideband advance ----------------
    always_comb begin
        n_sb[0]       = r_sb[0];
        n_sb[0].sel   = i_wheel_sel;
        n_sb[0].mode  = i_drive_mode;
        n_sb[0].v     = w_vcl[15:0];
        n_sb[0].thr   = w_thr;
        n_sb[0].th_hi = (w_th >= swsc_pkg::ANG_PI_2);
        n_sb[0].th_lo = (w_th <= -swsc_pkg::ANG_PI_2);
        n_sb[0].ang   = i_joint_angle;
        n_sb[0].rate  = i_joint_rate;
        for (int k = 1; k < SB_DEPTH; k++) begin
            n_sb[k] = r_sb[k-1];
        end
        n_sb[S_AB].a  = w_amb[W_AB+15:16];
        n_sb[S_AB].bb = w_apb[W_AB+15:16];
        n_sb[S_AB].y  = r_ls[W_AB+15:16];
        n_sb[S_AB].d  = w_d;
        n_sb[S_TGT].hl = w_hl;
        n_sb[S_TGT].hr = w_hr;
        n_sb[S_TGT].e  = W_E'(w_tgt) - W_E'($signed({w_vo.ang, 3'b000}));
        n_sb[S_SEL].sq = w_sq;
        n_sb[S_SEL].n  = w_n;
        n_sb[S_SEL].sd = w_sd;
        n_sb[S_STEER].steer = w_steer;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < SB_DEPTH; k++) begin
                r_sb[k] <= n_sb[k];
            end
        end
    end

    // ---------------- held rates and output register ----------------
    t_side              w_fo;
    logic               w_wh_ok;
    logic               w_live;
    logic [W_WIDX-1:0]  w_widx;
    logic signed [31:0] r_held_steer [NUM_WHEELS];
    logic signed [31:0] r_held_spin  [NUM_WHEELS];
    logic [2:0]         r_out_sel;
    logic signed [31:0] r_out_steer;
    logic signed [31:0] r_out_spin;

    assign w_fo    = r_sb[S_DIV_OUT];
    assign w_wh_ok = (w_fo.sel < 3'(NUM_WHEELS));
    assign w_live  = (w_fo.mode == swsc_pkg::MODE_CONT) || (w_fo.mode == swsc_pkg::MODE_POINT);
    assign w_widx  = w_fo.sel[W_WIDX-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WHEELS; k++) begin
                r_held_steer[k] <= '0;
                r_held_spin[k]  <= '0;
            end
        end else if (w_en && r_vld[LAST-1] && w_wh_ok && w_live) begin
            r_held_steer[w_widx] <= w_fo.steer;
            r_held_spin[w_widx]  <= w_spin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_sel <= w_fo.sel;
            if (!w_wh_ok) begin
                r_out_steer <= '0;
                r_out_spin  <= '0;
            end else if (!w_live) begin
                r_out_steer <= r_held_steer[w_widx];
                r_out_spin  <= r_held_spin[w_widx];
            end else begin
                r_out_steer <= w_fo.steer;
                r_out_spin  <= w_spin;
            end
        end
    end

    assign o_out_valid      = r_vld[LAST];
    assign o_wheel_echo     = r_out_sel;
    assign o_steer_rate_out = r_out_steer;
    assign o_spin_rate_out  = r_out_spin;

    // ---------------- assertions ----------------
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_in_valid && o_in_ready) && !(o_out_valid && i_out_ready))
        |=> ($countones(r_vld) == $past($countones(r_vld))))
        else $error("pipeline occupancy changed without a handshake");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid bits moved during a stall");

    a_bad_wheel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_wheel_echo >= 3'(NUM_WHEELS)))
        |-> (o_steer_rate_out == '0 && o_spin_rate_out == '0))
        else $error("out-of-range wheel produced nonzero rates");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused with an empty output register");

endmodule
